/* rtl/telp_pkg.sv */
// ----------------------------------------------------------------------------
// Text edge list parser package
// Shared types and character codes for the parser, statistics and top level.
// ----------------------------------------------------------------------------
package telp_pkg;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SKIP    = 3'd1,
    PH_SRC_WS  = 3'd2,
    PH_SRC_NUM = 3'd3,
    PH_DST_WS  = 3'd4,
    PH_DST_NUM = 3'd5,
    PH_TAIL    = 3'd6
  } phase_e;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [31:0] DEC_BASE  = 32'd10;

  localparam int unsigned VertexW = 32;
  localparam int unsigned MaxW    = 31;
  localparam int unsigned CountW  = 40;

  typedef struct packed {
    logic signed [VertexW-1:0] src;
    logic signed [VertexW-1:0] dst;
  } edge_t;

endpackage

/* rtl/telp_parser.sv */
// ----------------------------------------------------------------------------
// Text edge list line parser
// Consumes one byte per accepted word, tracks the line phase and number
// accumulator, and loads a completed edge into the edge register.
// ----------------------------------------------------------------------------
module telp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  input  logic                 edge_take_i,
  output logic                 edge_vld_o,
  output telp_pkg::edge_t      edge_o
);

  telp_pkg::phase_e phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      held_q, held_d;
  logic             edge_vld_q, edge_vld_d;
  telp_pkg::edge_t  edge_q, edge_d;

  function automatic logic [31:0] sval(input logic [31:0] v, input logic n);
    sval = n ? (32'd0 - v) : v;
  endfunction

  logic        is_nl, is_blank, is_minus, is_digit, is_hash;
  logic [31:0] digit;
  logic        in_line;
  logic        emit;

  assign is_nl    = (text_byte_i == telp_pkg::CHAR_NL);
  assign is_hash  = (text_byte_i == telp_pkg::CHAR_HASH);
  assign is_minus = (text_byte_i == telp_pkg::CHAR_MINUS);
  assign is_blank = (text_byte_i == telp_pkg::CHAR_SPACE) ||
                    (text_byte_i == telp_pkg::CHAR_TAB);
  assign is_digit = (text_byte_i >= telp_pkg::CHAR_ZERO) &&
                    (text_byte_i <= telp_pkg::CHAR_NINE);
  assign digit    = {28'd0, text_byte_i[3:0]};

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    held_d  = held_q;
    in_line = 1'b0;
    emit    = 1'b0;
    edge_d  = edge_q;

    unique case (phase_q)
      telp_pkg::PH_START: begin
        if (is_hash) begin
          phase_d = telp_pkg::PH_SKIP;
        end else if (!is_nl) begin
          acc_d   = '0;
          neg_d   = 1'b0;
          held_d  = '0;
          phase_d = telp_pkg::PH_SRC_WS;
        end
      end
      telp_pkg::PH_SKIP: begin
        if (is_nl) begin
          phase_d = telp_pkg::PH_START;
        end
      end
      telp_pkg::PH_SRC_WS, telp_pkg::PH_SRC_NUM, telp_pkg::PH_DST_WS,
      telp_pkg::PH_DST_NUM, telp_pkg::PH_TAIL: ;
      default: phase_d = telp_pkg::PH_START;
    endcase

    in_line = (phase_d == telp_pkg::PH_SRC_WS) || (phase_d == telp_pkg::PH_SRC_NUM) ||
              (phase_d == telp_pkg::PH_DST_WS) || (phase_d == telp_pkg::PH_DST_NUM) ||
              (phase_d == telp_pkg::PH_TAIL);

    if (in_line) begin
      // source number
      if (phase_d == telp_pkg::PH_SRC_WS || phase_d == telp_pkg::PH_SRC_NUM) begin
        if (phase_d == telp_pkg::PH_SRC_WS && is_blank) begin
        end else if (phase_d == telp_pkg::PH_SRC_WS && is_minus) begin
          neg_d   = 1'b1;
          phase_d = telp_pkg::PH_SRC_NUM;
        end else if (is_digit) begin
          acc_d   = 32'(acc_d * telp_pkg::DEC_BASE) + digit;
          phase_d = telp_pkg::PH_SRC_NUM;
        end else begin
          held_d  = sval(acc_d, neg_d);
          acc_d   = '0;
          neg_d   = 1'b0;
          phase_d = telp_pkg::PH_DST_WS;
        end
      end
      // destination number, may start at the byte that ended the source
      if (phase_d == telp_pkg::PH_DST_WS || phase_d == telp_pkg::PH_DST_NUM) begin
        if (phase_d == telp_pkg::PH_DST_WS && is_blank) begin
        end else if (phase_d == telp_pkg::PH_DST_WS && is_minus) begin
          neg_d   = 1'b1;
          phase_d = telp_pkg::PH_DST_NUM;
        end else if (is_digit) begin
          acc_d   = 32'(acc_d * telp_pkg::DEC_BASE) + digit;
          phase_d = telp_pkg::PH_DST_NUM;
        end else begin
          acc_d   = sval(acc_d, neg_d);
          neg_d   = 1'b0;
          phase_d = telp_pkg::PH_TAIL;
        end
      end

      // close any open number as if a non-digit followed
      if (phase_d == telp_pkg::PH_SRC_WS || phase_d == telp_pkg::PH_SRC_NUM) begin
        edge_d.src = sval(acc_d, neg_d);
        edge_d.dst = '0;
      end else if (phase_d == telp_pkg::PH_DST_WS || phase_d == telp_pkg::PH_DST_NUM) begin
        edge_d.src = held_d;
        edge_d.dst = sval(acc_d, neg_d);
      end else begin
        edge_d.src = held_d;
        edge_d.dst = acc_d;
      end

      if (is_nl) begin
        emit    = 1'b1;
        phase_d = telp_pkg::PH_START;
      end else if (end_of_text_i) begin
        emit    = 1'b1;
      end
    end

    if (end_of_text_i) begin
      phase_d = telp_pkg::PH_START;
      neg_d   = 1'b0;
      acc_d   = '0;
    end
  end

  assign edge_vld_d = (accept_i && emit) || (edge_vld_q && !edge_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= telp_pkg::PH_START;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      held_q     <= '0;
      edge_vld_q <= 1'b0;
    end else begin
      edge_vld_q <= edge_vld_d;
      if (accept_i) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      edge_q <= edge_d;
    end
  end

  assign edge_vld_o = edge_vld_q;
  assign edge_o     = edge_q;

  a_eot_resets_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_text_i |=> phase_q == telp_pkg::PH_START && acc_q == '0 && !neg_q)
    else $error("line state not cleared after end of text");

  a_edge_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(edge_vld_q) |-> $past(accept_i))
    else $error("edge appeared without an accepted word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !edge_vld_q || edge_take_i)
    else $error("word accepted while edge register blocked");

endmodule

/* rtl/telp_stats.sv */
// ----------------------------------------------------------------------------
// Edge statistics and result register
// Tracks the running maximum vertex id and saturating edge count, and holds
// the result word until it is taken.
// ----------------------------------------------------------------------------
module telp_stats (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               edge_vld_i,
  input  telp_pkg::edge_t                    edge_i,
  output logic                               edge_take_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [telp_pkg::VertexW-1:0] source_vertex_o,
  output logic signed [telp_pkg::VertexW-1:0] dest_vertex_o,
  output logic [telp_pkg::MaxW-1:0]          max_vertex_id_o,
  output logic [telp_pkg::CountW-1:0]        edge_total_o
);

  localparam logic [telp_pkg::CountW-1:0] CntMax = '1;

  logic                          out_vld_q;
  logic [telp_pkg::MaxW-1:0]     rmax_q, rmax_d, rmax_mid;
  logic [telp_pkg::CountW-1:0]   cnt_q, cnt_d;
  telp_pkg::edge_t               res_q;
  logic                          take;

  function automatic logic [telp_pkg::MaxW-1:0] upd_max(
    input logic [telp_pkg::VertexW-1:0] v,
    input logic [telp_pkg::MaxW-1:0]    m
  );
    upd_max = (!v[telp_pkg::VertexW-1] && (v[telp_pkg::MaxW-1:0] > m)) ?
              v[telp_pkg::MaxW-1:0] : m;
  endfunction

  assign take     = edge_vld_i && (!out_vld_q || out_ready_i);
  assign rmax_mid = upd_max(edge_i.src, rmax_q);
  assign rmax_d   = upd_max(edge_i.dst, rmax_mid);
  assign cnt_d    = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rmax_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (take) begin
        out_vld_q <= 1'b1;
        rmax_q    <= rmax_d;
        cnt_q     <= cnt_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= edge_i;
    end
  end

  assign edge_take_o     = take;
  assign out_valid_o     = out_vld_q;
  assign source_vertex_o = res_q.src;
  assign dest_vertex_o   = res_q.dst;
  assign max_vertex_id_o = rmax_q;
  assign edge_total_o    = cnt_q;

  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> rmax_q >= $past(rmax_q))
    else $error("running maximum decreased");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cnt_q != CntMax |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("edge count did not advance by one");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(cnt_q) && $stable(rmax_q))
    else $error("statistics changed without an edge");

endmodule

/* rtl/text_edge_list_parser_unit.sv */
// ----------------------------------------------------------------------------
// Text edge list parser unit
// Turns a byte stream of a text edge list into binary edge words.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle with no gaps while the result side keeps
// up. The line state (phase, sign, number accumulator) is updated once per
// accepted byte; the multiply-by-ten add of that loop sets the clock period.
// A finished edge goes to an edge register, then through the statistics stage
// (running maximum id, saturating count) into the result register, from
// which its word is offered. Comment lines and empty lines produce no word.
// Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module text_edge_list_parser_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          text_byte_i,
  input  logic                                end_of_text_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [telp_pkg::VertexW-1:0] source_vertex_o,
  output logic signed [telp_pkg::VertexW-1:0] dest_vertex_o,
  output logic [telp_pkg::MaxW-1:0]           max_vertex_id_o,
  output logic [telp_pkg::CountW-1:0]         edge_total_o
);

  logic            accept;
  logic            edge_vld;
  logic            edge_take;
  telp_pkg::edge_t edge_w;

  assign in_ready_o = !edge_vld || edge_take;
  assign accept     = in_valid_i && in_ready_o;

  telp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .edge_take_i  (edge_take),
    .edge_vld_o   (edge_vld),
    .edge_o       (edge_w)
  );

  telp_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .edge_vld_i     (edge_vld),
    .edge_i         (edge_w),
    .edge_take_o    (edge_take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .source_vertex_o(source_vertex_o),
    .dest_vertex_o  (dest_vertex_o),
    .max_vertex_id_o(max_vertex_id_o),
    .edge_total_o   (edge_total_o)
  );

endmodule

/* test/text_edge_list_parser_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text edge list parser checker
// Watches both channels of the parser. Every accepted text byte is run
// through a bit-accurate line parser with its own copy of the line state,
// the running maximum id and the edge count. Each edge it completes is
// queued, and each edge word the block hands out is compared field by field
// with the oldest queued edge. It reports the mismatch count and the number
// of edges still outstanding.
// ----------------------------------------------------------------------------
module text_edge_list_parser_unit_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [7:0]                          text_byte_i,
  input  logic                                end_of_text_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [telp_pkg::VertexW-1:0] source_vertex_i,
  input  logic signed [telp_pkg::VertexW-1:0] dest_vertex_i,
  input  logic [telp_pkg::MaxW-1:0]           max_vertex_id_i,
  input  logic [telp_pkg::CountW-1:0]         edge_total_i,
  output int                                  fail_count_o,
  output int                                  pending_count_o
);

  localparam logic [7:0] NulByte = 8'h00;

  typedef struct packed {
    logic signed [telp_pkg::VertexW-1:0] src;
    logic signed [telp_pkg::VertexW-1:0] dst;
    logic [telp_pkg::MaxW-1:0]           max_id;
    logic [telp_pkg::CountW-1:0]         total;
  } edge_word_t;

  edge_word_t                   expected_edges[$];
  telp_pkg::phase_e             cur_phase;
  logic                         minus_seen;
  logic [telp_pkg::VertexW-1:0] acc_value;
  logic [telp_pkg::VertexW-1:0] src_hold;
  logic [telp_pkg::MaxW-1:0]    top_id;
  logic [telp_pkg::CountW-1:0]  edges_seen;

  function automatic logic [telp_pkg::VertexW-1:0] signed_acc();
    return minus_seen ? (32'd0 - acc_value) : acc_value;
  endfunction

  function automatic void read_number_byte(input logic [7:0] c);
    logic blank;
    logic digit;
    blank = (c == telp_pkg::CHAR_SPACE) || (c == telp_pkg::CHAR_TAB);
    digit = (c >= telp_pkg::CHAR_ZERO) && (c <= telp_pkg::CHAR_NINE);
    if (cur_phase == telp_pkg::PH_SRC_WS || cur_phase == telp_pkg::PH_SRC_NUM) begin
      if (cur_phase == telp_pkg::PH_SRC_WS && blank) return;
      if (cur_phase == telp_pkg::PH_SRC_WS && c == telp_pkg::CHAR_MINUS) begin
        minus_seen = 1'b1;
        cur_phase  = telp_pkg::PH_SRC_NUM;
        return;
      end
      if (digit) begin
        acc_value = acc_value * telp_pkg::DEC_BASE + {24'd0, c - telp_pkg::CHAR_ZERO};
        cur_phase = telp_pkg::PH_SRC_NUM;
        return;
      end
      src_hold   = signed_acc();
      acc_value  = '0;
      minus_seen = 1'b0;
      cur_phase  = telp_pkg::PH_DST_WS;
    end
    if (cur_phase == telp_pkg::PH_DST_WS || cur_phase == telp_pkg::PH_DST_NUM) begin
      if (cur_phase == telp_pkg::PH_DST_WS && blank) return;
      if (cur_phase == telp_pkg::PH_DST_WS && c == telp_pkg::CHAR_MINUS) begin
        minus_seen = 1'b1;
        cur_phase  = telp_pkg::PH_DST_NUM;
        return;
      end
      if (digit) begin
        acc_value = acc_value * telp_pkg::DEC_BASE + {24'd0, c - telp_pkg::CHAR_ZERO};
        cur_phase = telp_pkg::PH_DST_NUM;
        return;
      end
      acc_value  = signed_acc();
      minus_seen = 1'b0;
      cur_phase  = telp_pkg::PH_TAIL;
    end
  endfunction

  function automatic void record_edge(output edge_word_t w);
    if (!src_hold[telp_pkg::VertexW-1] && src_hold[telp_pkg::MaxW-1:0] > top_id)
      top_id = src_hold[telp_pkg::MaxW-1:0];
    if (!acc_value[telp_pkg::VertexW-1] && acc_value[telp_pkg::MaxW-1:0] > top_id)
      top_id = acc_value[telp_pkg::MaxW-1:0];
    if (edges_seen != {telp_pkg::CountW{1'b1}}) edges_seen = edges_seen + 1'b1;
    w.src    = src_hold;
    w.dst    = acc_value;
    w.max_id = top_id;
    w.total  = edges_seen;
  endfunction

  function automatic bit parse_text_byte(input logic [7:0] c, input logic eot,
                                         output edge_word_t w);
    bit made;
    made = 1'b0;
    w    = '0;
    if (cur_phase == telp_pkg::PH_START) begin
      if (c == telp_pkg::CHAR_HASH) begin
        cur_phase = telp_pkg::PH_SKIP;
      end else if (c != telp_pkg::CHAR_NL) begin
        acc_value  = '0;
        minus_seen = 1'b0;
        src_hold   = '0;
        cur_phase  = telp_pkg::PH_SRC_WS;
      end
    end else if (cur_phase == telp_pkg::PH_SKIP) begin
      if (c == telp_pkg::CHAR_NL) cur_phase = telp_pkg::PH_START;
    end
    if (cur_phase >= telp_pkg::PH_SRC_WS && cur_phase <= telp_pkg::PH_TAIL) begin
      read_number_byte(c);
      if (c == telp_pkg::CHAR_NL) begin
        record_edge(w);
        made      = 1'b1;
        cur_phase = telp_pkg::PH_START;
      end else if (eot) begin
        // close any open number as if a non-digit followed
        if (cur_phase != telp_pkg::PH_TAIL) read_number_byte(NulByte);
        record_edge(w);
        made = 1'b1;
      end
    end
    if (eot) begin
      cur_phase  = telp_pkg::PH_START;
      minus_seen = 1'b0;
      acc_value  = '0;
    end
    return made;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    edge_word_t want;
    if (!rst_ni) begin
      expected_edges.delete();
      cur_phase       = telp_pkg::PH_START;
      minus_seen      = 1'b0;
      acc_value       = '0;
      src_hold        = '0;
      top_id          = '0;
      edges_seen      = '0;
      fail_count_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (parse_text_byte(text_byte_i, end_of_text_i, want)) expected_edges.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_edges.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word src %0d dst %0d max %0d total %0d", $time,
                   source_vertex_i, dest_vertex_i, max_vertex_id_i, edge_total_i);
        end else begin
          want = expected_edges.pop_front();
          if (source_vertex_i !== want.src) begin
            fail_count_o++;
            $display("%0t: source_vertex expected %0d got %0d", $time, want.src,
                     source_vertex_i);
          end
          if (dest_vertex_i !== want.dst) begin
            fail_count_o++;
            $display("%0t: dest_vertex expected %0d got %0d", $time, want.dst,
                     dest_vertex_i);
          end
          if (max_vertex_id_i !== want.max_id) begin
            fail_count_o++;
            $display("%0t: max_vertex_id expected %0d got %0d", $time, want.max_id,
                     max_vertex_id_i);
          end
          if (edge_total_i !== want.total) begin
            fail_count_o++;
            $display("%0t: edge_total expected %0d got %0d", $time, want.total,
                     edge_total_i);
          end
        end
      end
    end
    pending_count_o = expected_edges.size();
  end

endmodule

/* test/text_edge_list_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text edge list parser testbench
// Feeds the parser a short directed text covering comments, empty lines,
// signs, blanks, stray bytes and several ways a line can meet end of text, then
// about sixteen hundred bytes of random lines, mostly well-formed edge lines
// with random numbers and some noise. The sender idles in bursts and the
// receiver stalls on patterns of its own, with one long hold-off and one
// full drain. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module text_edge_list_parser_unit_tb;

  localparam int unsigned BytesTarget = 1600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 20;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic [7:0]                          text_byte_i;
  logic                                end_of_text_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [telp_pkg::VertexW-1:0] source_vertex_o;
  logic signed [telp_pkg::VertexW-1:0] dest_vertex_o;
  logic [telp_pkg::MaxW-1:0]           max_vertex_id_o;
  logic [telp_pkg::CountW-1:0]         edge_total_o;

  int         fail_count;
  int         pending_count;
  int         hold_req;
  int         bytes_sent;
  int         burst_left;
  bit         steady;
  logic [7:0] line_q[$];

  text_edge_list_parser_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .source_vertex_o (source_vertex_o),
    .dest_vertex_o   (dest_vertex_o),
    .max_vertex_id_o (max_vertex_id_o),
    .edge_total_o    (edge_total_o)
  );

  text_edge_list_parser_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .source_vertex_i (source_vertex_o),
    .dest_vertex_i   (dest_vertex_o),
    .max_vertex_id_i (max_vertex_id_o),
    .edge_total_i    (edge_total_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stall modes, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    int mode;
    int mode_left;
    int tick;
    out_ready_i = 1'b0;
    hold_left   = 0;
    hold_seen   = 0;
    mode        = 0;
    mode_left   = 0;
    tick        = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 1) != 0);
          default: out_ready_i <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!steady && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == telp_pkg::CHAR_NL) ? telp_pkg::CHAR_SPACE + 8'd12 : b;
  endfunction

  function automatic void push_blanks(input int n);
    repeat (n)
      line_q.push_back($urandom_range(0, 1) ? telp_pkg::CHAR_SPACE : telp_pkg::CHAR_TAB);
  endfunction

  function automatic void push_number();
    int digits;
    if ($urandom_range(0, 4) == 0) line_q.push_back(telp_pkg::CHAR_MINUS);
    case ($urandom_range(0, 9))
      0:       digits = 0;
      1, 2:    digits = $urandom_range(8, 12);
      default: digits = $urandom_range(1, 4);
    endcase
    repeat (digits) line_q.push_back(telp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  task automatic send_random_line();
    int kind;
    int last;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      push_blanks($urandom_range(0, 2));
      push_number();
      if ($urandom_range(0, 5) == 0) line_q.push_back(junk_byte());
      else push_blanks($urandom_range(1, 3));
      push_number();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) line_q.push_back(junk_byte());
      line_q.push_back(telp_pkg::CHAR_NL);
    end else if (kind < 80) begin
      line_q.push_back(telp_pkg::CHAR_HASH);
      repeat ($urandom_range(0, 8)) line_q.push_back(junk_byte());
      line_q.push_back(telp_pkg::CHAR_NL);
    end else if (kind < 85) begin
      line_q.push_back(telp_pkg::CHAR_NL);
    end else begin
      repeat ($urandom_range(1, 8))
        line_q.push_back(($urandom_range(0, 7) == 0) ? telp_pkg::CHAR_NL :
                                                       8'($urandom_range(0, 255)));
    end
    last = line_q.size() - 1;
    if ($urandom_range(0, 19) == 0) last = $urandom_range(0, line_q.size() - 1);
    for (int i = 0; i <= last; i++) send_byte(line_q[i], ($urandom_range(0, 19) == 0) ?
                                              (i == last) : (i == last && last != line_q.size() - 1));
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_byte_i   = '0;
    end_of_text_i = 1'b0;
    hold_req      = 0;
    bytes_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_text("#x\n", 1'b0);
    send_text("\n", 1'b0);
    send_text("-7\t9\n", 1'b0);
    send_text("12 3", 1'b1);
    send_text("5", 1'b1);
    send_text("8 9\n", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(telp_pkg::CHAR_NL, 1'b0);
    send_text("#", 1'b1);

    while (bytes_sent < BytesTarget) begin
      if (!hold_done && bytes_sent >= 500) begin
        hold_done = 1'b1;
        hold_req++;
      end
      if (!drain_done && bytes_sent >= 1000) begin
        drain_done = 1'b1;
        pause_sender(1);
        wait (pending_count == 0);
      end
      steady = (bytes_sent >= 700) && (bytes_sent < 900);
      send_random_line();
    end

    pause_sender(1);
    wait (pending_count == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
